>>> rtl/sbn_pkg.sv
// ----------------------------------------------------------------------------
// SBN deframer package
// Shared types and constants for the frame deframer front, queue and back.
// ----------------------------------------------------------------------------
package sbn_pkg;

   // parser phase
   typedef enum logic [1:0] {
      PHASE_HUNT    = 2'd0,
      PHASE_FRAME   = 2'd1,
      PHASE_PRODUCT = 2'd2,
      PHASE_PAYLOAD = 2'd3
   } phase_type;

   // result kind code
   typedef enum logic [1:0] {
      KIND_PAYLOAD = 2'd0,
      KIND_START   = 2'd1,
      KIND_ERROR   = 2'd2
   } kind_type;

   localparam logic [7:0]  SYNC_VALUE      = 8'hFF;
   localparam logic [15:0] FRAME_HDR_LEN   = 16'd16;

   // frame byte positions
   localparam logic [4:0] IDX_FIRST_DATA  = 5'd1;
   localparam logic [4:0] IDX_SEQ_FIRST   = 5'd8;
   localparam logic [4:0] IDX_SEQ_LAST    = 5'd11;
   localparam logic [4:0] IDX_RUN_HI      = 5'd12;
   localparam logic [4:0] IDX_RUN_LO      = 5'd13;
   localparam logic [4:0] IDX_SUM_END     = 5'd14;
   localparam logic [4:0] IDX_CSUM_LO     = 5'd15;
   localparam logic [4:0] IDX_PRODUCT     = 5'd16;
   localparam logic [4:0] IDX_HLEN_HI     = 5'd18;
   localparam logic [4:0] IDX_HLEN_LO     = 5'd19;
   localparam logic [4:0] IDX_OFFS_HI     = 5'd22;
   localparam logic [4:0] IDX_OFFS_LO     = 5'd23;
   localparam logic [4:0] IDX_SIZE_HI     = 5'd24;
   localparam logic [4:0] IDX_SIZE_LO     = 5'd25;

   // one classified event from the front
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  data;
      logic        last;
      logic [31:0] seq;
      logic [15:0] run;
      logic [15:0] hdr_len;
      logic [15:0] offset;
      logic [15:0] size;
   } rec_type;

   typedef struct packed {
      logic    valid;
      rec_type rec;
   } push_type;

endpackage

>>> rtl/sbn_parse.sv
// ----------------------------------------------------------------------------
// SBN frame parser
// Walks the byte stream through hunt, frame header, product header and
// payload, and pushes one event record per result into the queue.
// ----------------------------------------------------------------------------
module sbn_parse (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [7:0]        data_byte,
   output sbn_pkg::push_type push
);

   sbn_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  count_ff, count_in;
   logic [15:0] sum_ff, sum_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] run_ff, run_in;
   logic [15:0] csum_ff, csum_in;
   logic [15:0] hlen_ff, hlen_in;
   logic [15:0] offs_ff, offs_in;
   logic [15:0] remain_ff, remain_in;

   logic [15:0] csum_shift;
   logic [15:0] size_shift;
   logic [15:0] remain_dec;
   logic        csum_bad;

   assign csum_shift = {csum_ff[7:0], data_byte};
   assign size_shift = {remain_ff[7:0], data_byte};
   assign remain_dec = remain_ff - 16'd1;
   assign csum_bad   = (csum_shift != sum_ff);

   // next phase
   always_comb begin
      phase_in = phase_ff;
      if (fire) begin
         unique case (phase_ff)
            sbn_pkg::PHASE_HUNT: begin
               if (data_byte == sbn_pkg::SYNC_VALUE) phase_in = sbn_pkg::PHASE_FRAME;
            end
            sbn_pkg::PHASE_FRAME: begin
               if (count_ff >= sbn_pkg::IDX_CSUM_LO) begin
                  phase_in = csum_bad ? sbn_pkg::PHASE_HUNT : sbn_pkg::PHASE_PRODUCT;
               end
            end
            sbn_pkg::PHASE_PRODUCT: begin
               if (count_ff >= sbn_pkg::IDX_SIZE_LO) begin
                  phase_in = (size_shift != 16'd0) ? sbn_pkg::PHASE_PAYLOAD
                                                   : sbn_pkg::PHASE_HUNT;
               end
            end
            sbn_pkg::PHASE_PAYLOAD: begin
               if (remain_dec == 16'd0) phase_in = sbn_pkg::PHASE_HUNT;
            end
            default: phase_in = sbn_pkg::PHASE_HUNT;
         endcase
      end
   end

   // field capture and event output
   always_comb begin
      count_in  = count_ff;
      sum_in    = sum_ff;
      seq_in    = seq_ff;
      run_in    = run_ff;
      csum_in   = csum_ff;
      hlen_in   = hlen_ff;
      offs_in   = offs_ff;
      remain_in = remain_ff;
      push          = '0;
      push.rec.seq  = seq_ff;
      push.rec.run  = run_ff;
      push.rec.hdr_len = hlen_ff;
      push.rec.offset  = offs_ff;
      if (fire) begin
         unique case (phase_ff)
            sbn_pkg::PHASE_HUNT: begin
               if (data_byte == sbn_pkg::SYNC_VALUE) begin
                  count_in = sbn_pkg::IDX_FIRST_DATA;
                  sum_in   = {8'd0, sbn_pkg::SYNC_VALUE};
               end
            end
            sbn_pkg::PHASE_FRAME: begin
               if (count_ff < sbn_pkg::IDX_SUM_END) sum_in = sum_ff + {8'd0, data_byte};
               if (count_ff >= sbn_pkg::IDX_SEQ_FIRST && count_ff <= sbn_pkg::IDX_SEQ_LAST) begin
                  seq_in = {seq_ff[23:0], data_byte};
               end else if (count_ff == sbn_pkg::IDX_RUN_HI ||
                            count_ff == sbn_pkg::IDX_RUN_LO) begin
                  run_in = {run_ff[7:0], data_byte};
               end else if (count_ff >= sbn_pkg::IDX_SUM_END) begin
                  csum_in = csum_shift;
               end
               if (count_ff >= sbn_pkg::IDX_CSUM_LO) begin
                  if (csum_bad) begin
                     count_in      = '0;
                     push.valid    = 1'b1;
                     push.rec.kind = sbn_pkg::KIND_ERROR;
                  end else begin
                     count_in = sbn_pkg::IDX_PRODUCT;
                  end
               end else begin
                  count_in = count_ff + 5'd1;
               end
            end
            sbn_pkg::PHASE_PRODUCT: begin
               if (count_ff == sbn_pkg::IDX_HLEN_HI || count_ff == sbn_pkg::IDX_HLEN_LO) begin
                  hlen_in = {hlen_ff[7:0], data_byte};
               end else if (count_ff == sbn_pkg::IDX_OFFS_HI ||
                            count_ff == sbn_pkg::IDX_OFFS_LO) begin
                  offs_in = {offs_ff[7:0], data_byte};
               end else if (count_ff == sbn_pkg::IDX_SIZE_HI ||
                            count_ff == sbn_pkg::IDX_SIZE_LO) begin
                  remain_in = size_shift;
               end
               if (count_ff >= sbn_pkg::IDX_SIZE_LO) begin
                  count_in      = '0;
                  push.valid    = 1'b1;
                  push.rec.kind = sbn_pkg::KIND_START;
                  push.rec.size = remain_in;
                  push.rec.last = (remain_in == 16'd0);
               end else begin
                  count_in = count_ff + 5'd1;
               end
            end
            sbn_pkg::PHASE_PAYLOAD: begin
               remain_in     = remain_dec;
               push.valid    = 1'b1;
               push.rec.kind = sbn_pkg::KIND_PAYLOAD;
               push.rec.data = data_byte;
               push.rec.last = (remain_dec == 16'd0);
               if (remain_dec == 16'd0) count_in = '0;
            end
            default: count_in = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sbn_pkg::PHASE_HUNT;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
      end
      sum_ff    <= sum_in;
      seq_ff    <= seq_in;
      run_ff    <= run_in;
      csum_ff   <= csum_in;
      hlen_ff   <= hlen_in;
      offs_ff   <= offs_in;
      remain_ff <= remain_in;
   end

endmodule

>>> rtl/sbn_queue.sv
// ----------------------------------------------------------------------------
// SBN event queue
// Small register FIFO of event records between parser and result stage.
// ----------------------------------------------------------------------------
module sbn_queue #(
   parameter int DEPTH = 2
) (
   input  logic              clock,
   input  logic              reset,
   input  sbn_pkg::push_type push,
   output logic              full,
   output logic              rd_valid,
   output sbn_pkg::rec_type  rd_rec,
   input  logic              pop
);

   localparam int PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CntW = $clog2(DEPTH + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
   localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

   sbn_pkg::rec_type mem_ff [DEPTH];
   logic [PtrW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CntFull);
   assign rd_valid = (cnt_ff != '0);
   assign rd_rec   = mem_ff[rd_ptr_ff];
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && rd_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) wr_ptr_in = (wr_ptr_ff == PtrLast) ? '0 : wr_ptr_ff + PtrW'(1);
      if (do_pop)  rd_ptr_in = (rd_ptr_ff == PtrLast) ? '0 : rd_ptr_ff + PtrW'(1);
      if (do_push && !do_pop)      cnt_in = cnt_ff + CntW'(1);
      else if (!do_push && do_pop) cnt_in = cnt_ff - CntW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (do_push) mem_ff[wr_ptr_ff] <= push.rec;
   end

endmodule

>>> rtl/sbn_emit.sv
// ----------------------------------------------------------------------------
// SBN result stage
// Pops events, keeps run and table bookkeeping, forms the result fields
// and holds them in the output register.
// ----------------------------------------------------------------------------
module sbn_emit (
   input  logic             clock,
   input  logic             reset,
   input  logic             rd_valid,
   input  sbn_pkg::rec_type rd_rec,
   output logic             pop,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [1:0]       rsp_kind,
   output logic [7:0]       rsp_payload_byte,
   output logic             rsp_last,
   output logic [31:0]      rsp_sequence_number,
   output logic [15:0]      rsp_run_number,
   output logic             rsp_run_changed,
   output logic             rsp_table_select,
   output logic [15:0]      rsp_data_block_start,
   output logic [15:0]      rsp_payload_size
);

   logic        valid_ff, valid_in;
   logic [15:0] prev_run_ff, prev_run_in;
   logic        table_ff, table_in;
   logic [1:0]  kind_ff, kind_in;
   logic [7:0]  byte_ff, byte_in;
   logic        last_ff, last_in;
   logic [31:0] seq_ff, seq_in;
   logic [15:0] run_ff, run_in;
   logic        chg_ff, chg_in;
   logic        tsel_ff, tsel_in;
   logic [15:0] start_ff, start_in;
   logic [15:0] size_ff, size_in;
   logic        changed;

   assign pop     = rd_valid && (!valid_ff || rsp_ready);
   assign changed = (prev_run_ff != 16'd0) && (prev_run_ff != rd_rec.run);

   always_comb begin
      valid_in    = valid_ff;
      prev_run_in = prev_run_ff;
      table_in    = table_ff;
      kind_in     = kind_ff;
      byte_in     = byte_ff;
      last_in     = last_ff;
      seq_in      = seq_ff;
      run_in      = run_ff;
      chg_in      = chg_ff;
      tsel_in     = tsel_ff;
      start_in    = start_ff;
      size_in     = size_ff;
      if (rsp_ready) valid_in = 1'b0;
      if (pop) begin
         valid_in = 1'b1;
         kind_in  = rd_rec.kind;
         byte_in  = '0;
         last_in  = 1'b0;
         seq_in   = '0;
         run_in   = '0;
         chg_in   = 1'b0;
         tsel_in  = 1'b0;
         start_in = '0;
         size_in  = '0;
         unique case (rd_rec.kind)
            sbn_pkg::KIND_PAYLOAD: begin
               byte_in = rd_rec.data;
               last_in = rd_rec.last;
            end
            sbn_pkg::KIND_START: begin
               table_in    = table_ff ^ changed;
               prev_run_in = rd_rec.run;
               last_in     = rd_rec.last;
               seq_in      = rd_rec.seq;
               run_in      = rd_rec.run;
               chg_in      = changed;
               tsel_in     = table_ff ^ changed;
               start_in    = sbn_pkg::FRAME_HDR_LEN + rd_rec.hdr_len + rd_rec.offset;
               size_in     = rd_rec.size;
            end
            default: begin
               // checksum error: every other field stays zero
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         prev_run_ff <= '0;
         table_ff    <= 1'b0;
      end else begin
         valid_ff    <= valid_in;
         prev_run_ff <= prev_run_in;
         table_ff    <= table_in;
      end
      kind_ff  <= kind_in;
      byte_ff  <= byte_in;
      last_ff  <= last_in;
      seq_ff   <= seq_in;
      run_ff   <= run_in;
      chg_ff   <= chg_in;
      tsel_ff  <= tsel_in;
      start_ff <= start_in;
      size_ff  <= size_in;
   end

   assign rsp_valid            = valid_ff;
   assign rsp_kind             = kind_ff;
   assign rsp_payload_byte     = byte_ff;
   assign rsp_last             = last_ff;
   assign rsp_sequence_number  = seq_ff;
   assign rsp_run_number       = run_ff;
   assign rsp_run_changed      = chg_ff;
   assign rsp_table_select     = tsel_ff;
   assign rsp_data_block_start = start_ff;
   assign rsp_payload_size     = size_ff;

endmodule

>>> rtl/sbn_frame_deframer.sv
// ----------------------------------------------------------------------------
// SBN frame deframer
// A result passes through the event queue and the output register on its
// way to rsp_*. Throughput: one byte per cycle; the parser takes a byte
// whenever the event queue has a free slot, so a stalled output backs up
// after QUEUE_DEPTH plus one held results.
// Reset (synchronous): hunt for sync, queue and output empty, previous
// run 0, first session table selected.
// ----------------------------------------------------------------------------
module sbn_frame_deframer #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last,
   output logic [31:0] rsp_sequence_number,
   output logic [15:0] rsp_run_number,
   output logic        rsp_run_changed,
   output logic        rsp_table_select,
   output logic [15:0] rsp_data_block_start,
   output logic [15:0] rsp_payload_size
);

   // Front: the parser consumes one byte per transfer and classifies it.
   // Hunting bytes and header bytes produce no event; checksum errors,
   // frame starts and payload bytes push one record each.
   sbn_pkg::push_type push;
   sbn_pkg::rec_type  rd_rec;
   logic              q_full;
   logic              rd_valid;
   logic              pop;
   logic              fire;

   // Accept whenever the queue has room; the parser itself never stalls.
   assign req_ready = !q_full;
   assign fire      = req_valid && req_ready;

   sbn_parse u_parse (
      .clock     (clock),
      .reset     (reset),
      .fire      (fire),
      .data_byte (req_data_byte),
      .push      (push)
   );

   // Queue: decouples the parser from output backpressure.
   sbn_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .full     (q_full),
      .rd_valid (rd_valid),
      .rd_rec   (rd_rec),
      .pop      (pop)
   );

   // Back: run-change tracking, table toggle, data start sum and the
   // output register. Advance a record only when the output slot frees.
   sbn_emit u_emit (
      .clock                (clock),
      .reset                (reset),
      .rd_valid             (rd_valid),
      .rd_rec               (rd_rec),
      .pop                  (pop),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_kind             (rsp_kind),
      .rsp_payload_byte     (rsp_payload_byte),
      .rsp_last             (rsp_last),
      .rsp_sequence_number  (rsp_sequence_number),
      .rsp_run_number       (rsp_run_number),
      .rsp_run_changed      (rsp_run_changed),
      .rsp_table_select     (rsp_table_select),
      .rsp_data_block_start (rsp_data_block_start),
      .rsp_payload_size     (rsp_payload_size)
   );

endmodule
